/* src/gli_pkg.sv */
// gli_pkg: shared types, codes and constants of the GPIO line interrupt controller.
// Depends on nothing; every other file of the block but gli_ram imports it.
package gli_pkg;

   localparam int MAX_LINES_DEFAULT = 64;
   localparam int QUEUE_DEPTH       = 2;

   localparam logic [6:0] LINES_RESET = 7'd64;

   // item modes
   localparam logic [2:0] MODE_GET_DIR = 3'd0;
   localparam logic [2:0] MODE_SET_DIR = 3'd1;
   localparam logic [2:0] MODE_GET_VAL = 3'd2;
   localparam logic [2:0] MODE_SET_VAL = 3'd3;
   localparam logic [2:0] MODE_SET_IRQ = 3'd4;
   localparam logic [2:0] MODE_UNMASK  = 3'd5;
   localparam logic [2:0] MODE_PIN     = 3'd6;
   localparam logic [2:0] MODE_UNKNOWN = 3'd7;

   // interrupt type bits
   localparam logic [31:0] IRQ_NONE = 32'h0000_0000;
   localparam logic [31:0] IRQ_RISE = 32'h0000_0001;
   localparam logic [31:0] IRQ_FALL = 32'h0000_0002;
   localparam logic [31:0] IRQ_HIGH = 32'h0000_0004;
   localparam logic [31:0] IRQ_LOW  = 32'h0000_0008;

   // result kinds
   localparam logic KIND_RESPONSE = 1'b0;
   localparam logic KIND_EVENT    = 1'b1;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   localparam logic EVENT_INVALID = 1'b0;
   localparam logic EVENT_VALID   = 1'b1;

   typedef struct packed {
      logic [2:0]  mode;
      logic [15:0] line;
      logic [31:0] value;
      logic [15:0] buffer_tag;
   } req_item_type;

   typedef struct packed {
      logic        kind;
      logic        status;
      logic [7:0]  read_value;
      logic [15:0] event_tag;
      logic        event_status;
      logic        last;
   } rsp_item_type;

   // classified item as it waits in the queue
   typedef struct packed {
      logic [2:0]  mode;
      logic        line_ok;
      logic [15:0] line;
      logic [31:0] value;
      logic [15:0] buffer_tag;
   } work_item_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   // per-line state word held in one RAM entry
   typedef struct packed {
      logic [7:0]  direction;
      logic [7:0]  out_value;
      logic [7:0]  in_level;
      logic [31:0] irq_type;
      logic        irq_waiting;
      logic        buffer_armed;
   } line_state_type;

endpackage

/* src/gli_ram.sv */
// gli_ram: generic single-write, single-read RAM with registered read data.
// Depends on nothing; used for the per-line state and the armed tag stores.
module gli_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/gli_queue.sv */
// gli_queue: short FIFO of classified items between front and back.
// Depends on gli_pkg.
module gli_queue
   import gli_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  work_item_type    push_item,
   input  logic             pop,
   output work_item_type    head_item,
   output queue_status_type status
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   work_item_type    slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
      next_ptr = (ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
   endfunction

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item    = slot_ff[rd_ptr_ff];
   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CNT_W'(QUEUE_DEPTH));

endmodule

/* src/gli_front.sv */
// gli_front: accepts items, holds lines_in_use, checks the line and queues or drops the item.
// Depends on gli_pkg.
module gli_front
   import gli_pkg::*;
#(
   parameter int MAX_LINES = MAX_LINES_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [6:0]       csr_wr_data,
   input  logic             start,
   input  req_item_type     req_item,
   output logic             busy,
   input  queue_status_type q_status,
   input  logic             clearing,
   output logic             push,
   output work_item_type    push_item
);

   logic [6:0]  lines_ff, lines_in;
   logic [15:0] valid_lines;
   logic        line_ok;
   logic        silent_drop;
   logic        accept;

   always_comb begin
      lines_in = csr_wr_en ? csr_wr_data : lines_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lines_ff <= LINES_RESET;
      end else begin
         lines_ff <= lines_in;
      end
   end

   always_comb begin
      valid_lines = (16'(lines_ff) < 16'(MAX_LINES)) ? 16'(lines_ff) : 16'(MAX_LINES);
      line_ok     = (req_item.line < valid_lines);
      // unmask and pin change on a bad line give nothing, so they stop here
      silent_drop = !line_ok && (req_item.mode inside {MODE_UNMASK, MODE_PIN});
      busy        = q_status.full || clearing;
      accept      = start && !busy;
      push        = accept && !silent_drop;

      push_item.mode       = req_item.mode;
      push_item.line_ok    = line_ok;
      push_item.line       = req_item.line;
      push_item.value      = req_item.value;
      push_item.buffer_tag = req_item.buffer_tag;
   end

endmodule

/* src/gli_back.sv */
// gli_back: per-line read-modify-write sequencer, state RAMs and result register.
// Depends on gli_pkg and gli_ram.
module gli_back
   import gli_pkg::*;
#(
   parameter int MAX_LINES = MAX_LINES_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type q_status,
   input  work_item_type    head_item,
   output logic             pop,
   output logic             clearing,
   output logic             rsp_valid,
   output rsp_item_type     rsp_item
);

   localparam int IDX_W = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
   localparam int ST_W  = $bits(line_state_type);

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_EXEC  = 2'd2;
   localparam logic [1:0] S_EMIT2 = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [IDX_W-1:0] clr_ff, clr_in;
   work_item_type    cur_ff, cur_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_item_type     rsp_ff, rsp_in;
   rsp_item_type     second_ff, second_in;

   line_state_type   st_rd, st_new, st_wdata;
   logic [ST_W-1:0]  st_rd_bits;
   logic             st_we;
   logic [IDX_W-1:0] st_waddr;
   logic [15:0]      tag_rd;
   logic             tag_we;

   logic             r1_valid;
   rsp_item_type     r1;
   logic             two;
   logic             st_upd;
   logic             fire;
   logic [7:0]       b;
   logic [IDX_W-1:0] cur_idx;

   gli_ram #(.WIDTH(ST_W), .DEPTH(MAX_LINES)) u_state_ram (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (st_waddr),
      .wr_data (st_wdata),
      .rd_addr (head_item.line[IDX_W-1:0]),
      .rd_data (st_rd_bits)
   );

   gli_ram #(.WIDTH(16), .DEPTH(MAX_LINES)) u_tag_ram (
      .clock   (clock),
      .wr_en   (tag_we),
      .wr_addr (cur_idx),
      .wr_data (cur_ff.buffer_tag),
      .rd_addr (head_item.line[IDX_W-1:0]),
      .rd_data (tag_rd)
   );

   assign st_rd   = line_state_type'(st_rd_bits);
   assign b       = cur_ff.value[7:0];
   assign cur_idx = cur_ff.line[IDX_W-1:0];

   // one item against the line word read in the previous cycle
   always_comb begin
      st_new   = st_rd;
      st_upd   = 1'b0;
      tag_we   = 1'b0;
      r1_valid = 1'b0;
      r1       = '0;
      two      = 1'b0;
      fire     = 1'b0;
      if (cur_ff.mode == MODE_UNMASK) begin
         r1.kind = KIND_EVENT;
         if (st_rd.irq_type == IRQ_NONE) begin
            r1_valid       = 1'b1;
            r1.event_tag   = cur_ff.buffer_tag;
            r1.event_status = EVENT_INVALID;
         end else if (st_rd.irq_waiting) begin
            r1_valid           = 1'b1;
            r1.event_tag       = cur_ff.buffer_tag;
            r1.event_status    = EVENT_VALID;
            st_new.irq_waiting = 1'b0;
            st_upd             = 1'b1;
         end else begin
            // an older armed buffer is handed back invalid
            r1_valid            = st_rd.buffer_armed;
            r1.event_tag        = tag_rd;
            r1.event_status     = EVENT_INVALID;
            st_new.buffer_armed = 1'b1;
            st_upd              = 1'b1;
            tag_we              = 1'b1;
         end
      end else if (cur_ff.mode == MODE_PIN) begin
         if (st_rd.in_level != b) begin
            st_new.in_level = b;
            st_upd          = 1'b1;
            fire = ((b != 8'd0) && ((st_rd.irq_type & (IRQ_RISE | IRQ_HIGH)) != IRQ_NONE)) ||
                   ((b == 8'd0) && ((st_rd.irq_type & (IRQ_FALL | IRQ_LOW)) != IRQ_NONE));
            if (fire) begin
               if (st_rd.buffer_armed) begin
                  r1_valid            = 1'b1;
                  r1.kind             = KIND_EVENT;
                  r1.event_tag        = tag_rd;
                  r1.event_status     = EVENT_VALID;
                  st_new.buffer_armed = 1'b0;
                  st_new.irq_waiting  = 1'b0;
               end else begin
                  st_new.irq_waiting = 1'b1;
               end
            end
         end
      end else if (!cur_ff.line_ok) begin
         r1_valid  = 1'b1;
         r1.kind   = KIND_RESPONSE;
         r1.status = STATUS_ERR;
      end else begin
         r1_valid = 1'b1;
         r1.kind  = KIND_RESPONSE;
         case (cur_ff.mode)
            MODE_GET_DIR: begin
               r1.read_value = st_rd.direction;
            end
            MODE_SET_DIR: begin
               st_new.direction = b;
               st_upd           = 1'b1;
            end
            MODE_GET_VAL: begin
               st_new.out_value = st_rd.in_level;
               st_upd           = 1'b1;
               r1.read_value    = st_rd.in_level;
            end
            MODE_SET_VAL: begin
               st_new.out_value = b;
               st_upd           = 1'b1;
            end
            MODE_SET_IRQ: begin
               if (cur_ff.value == st_rd.irq_type) begin
                  r1.status = STATUS_OK;
               end else if ((st_rd.irq_type != IRQ_NONE) && (cur_ff.value != IRQ_NONE)) begin
                  r1.status = STATUS_ERR;
               end else begin
                  if (cur_ff.value == IRQ_NONE) begin
                     st_new.irq_waiting = 1'b0;
                     if (st_rd.buffer_armed) begin
                        // armed buffer first, response follows
                        two                 = 1'b1;
                        st_new.buffer_armed = 1'b0;
                     end
                  end
                  st_new.irq_type = cur_ff.value;
                  st_upd          = 1'b1;
               end
            end
            default: begin
               r1.status = STATUS_ERR;
            end
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      cur_in       = cur_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      second_in    = second_ff;
      pop          = 1'b0;
      st_we        = 1'b0;
      st_waddr     = cur_idx;
      st_wdata     = st_new;
      case (state_ff)
         S_CLEAR: begin
            st_we    = 1'b1;
            st_waddr = clr_ff;
            st_wdata = '0;
            clr_in   = clr_ff + IDX_W'(1);
            if (clr_ff == IDX_W'(MAX_LINES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (!q_status.empty) begin
               pop      = 1'b1;
               cur_in   = head_item;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            st_we = st_upd;
            if (two) begin
               rsp_valid_in           = 1'b1;
               rsp_in                 = '0;
               rsp_in.kind            = KIND_EVENT;
               rsp_in.event_tag       = tag_rd;
               rsp_in.event_status    = EVENT_INVALID;
               second_in              = r1;
               second_in.last         = 1'b1;
               state_in               = S_EMIT2;
            end else begin
               rsp_valid_in = r1_valid;
               rsp_in       = r1;
               rsp_in.last  = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_EMIT2: begin
            rsp_valid_in = 1'b1;
            rsp_in       = second_ff;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      rsp_ff    <= rsp_in;
      second_ff <= second_in;
   end

   assign clearing  = (state_ff == S_CLEAR);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> (state_ff == S_IDLE))
      else $error("queue popped outside idle");

   a_emit2_after_exec: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT2) |-> ($past(state_ff) == S_EXEC))
      else $error("second result without exec");

   a_not_last_followed: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.last) |=> (rsp_valid_ff && rsp_ff.last))
      else $error("first of two results not followed by last");

   a_clear_writes_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> (st_we && (st_wdata == '0)))
      else $error("clearing pass skipped an entry");

endmodule

/* src/gpio_line_irq_controller.sv */
// gpio_line_irq_controller: top level of the per-line GPIO interrupt controller.
// Depends on gli_pkg, gli_front, gli_queue, gli_back (and gli_ram through gli_back).
//
// Sequence: with the back end idle, an accepted item is queued, popped in S_IDLE while
//    the RAMs are read and applied in S_EXEC, which registers its first result on the
//    rsp_ ports; a second result (interrupt type cleared with a buffer armed) follows
//    from S_EMIT2 in the next cycle. The back end runs one item at a time: RAM read,
//    then modify/write, then S_EMIT2 for two results; the two-entry queue absorbs bursts.
// Reset: synchronous; afterwards a clearing pass over all MAX_LINES entries zeroes the line
//    state RAM with busy high. The armed tag store is not cleared. Results cannot stall.
module gpio_line_irq_controller
   import gli_pkg::*;
#(
   parameter int MAX_LINES = MAX_LINES_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   // configuration: lines_in_use
   input  logic         csr_wr_en,
   input  logic [6:0]   csr_wr_data,
   // item input, taken when start is high and busy is low
   input  logic         start,
   output logic         busy,
   input  req_item_type req_item,
   // results, one cycle each, marked by rsp_valid
   output logic         rsp_valid,
   output rsp_item_type rsp_item
);

   queue_status_type q_status;
   logic             push;
   work_item_type    push_item;
   logic             pop;
   work_item_type    head_item;
   logic             clearing;

   // Front: owns lines_in_use, range-checks the line, drops unmask and pin change
   // items on a bad line (they give nothing) and queues everything else.
   gli_front #(.MAX_LINES(MAX_LINES)) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .start       (start),
      .req_item    (req_item),
      .busy        (busy),
      .q_status    (q_status),
      .clearing    (clearing),
      .push        (push),
      .push_item   (push_item)
   );

   // Queue: decouples acceptance from the back end's read-modify-write.
   gli_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .status    (q_status)
   );

   // Back: reads the line word and armed tag, applies the item, writes back and
   // registers the result(s). Items run one at a time, so no forwarding is needed.
   gli_back #(.MAX_LINES(MAX_LINES)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .head_item (head_item),
      .pop       (pop),
      .clearing  (clearing),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule
